/* hdl/http_response_header_classifier_assert.svh */
// assertion macros for the header name classifier top level
// expects clk and rst_n in the scope where a macro is used
`ifndef HTTP_RESPONSE_HEADER_CLASSIFIER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define HRHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrhc assertion failed");

// next-cycle implication
`define HRHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrhc assertion failed");

`endif

/* hdl/hrhc_pkg.sv */
// types, name table and helper functions for the header name classifier
// no dependencies
`default_nettype none

package hrhc_pkg;

    localparam int NUM_NAMES = 22;
    localparam int COUNT_W   = 6;
    localparam int CODE_W    = 5;
    localparam int NAME_BITS = 256;

    localparam logic [NUM_NAMES-1:0] ALL_ALIVE = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [CODE_W-1:0]    CODE_UNKNOWN = '0;

    // names right-justified, lower case
    localparam logic [NAME_BITS-1:0] NAME_STR [NUM_NAMES] = '{
        NAME_BITS'("date"),
        NAME_BITS'("etag"),
        NAME_BITS'("vary"),
        NAME_BITS'("allow"),
        NAME_BITS'("server"),
        NAME_BITS'("location"),
        NAME_BITS'("connection"),
        NAME_BITS'("set-cookie"),
        NAME_BITS'("content-type"),
        NAME_BITS'("accept-ranges"),
        NAME_BITS'("cache-control"),
        NAME_BITS'("content-range"),
        NAME_BITS'("last-modified"),
        NAME_BITS'("content-length"),
        NAME_BITS'("content-encoding"),
        NAME_BITS'("transfer-encoding"),
        NAME_BITS'("access-control-allow-origin"),
        NAME_BITS'("access-control-allow-methods"),
        NAME_BITS'("access-control-allow-headers"),
        NAME_BITS'("access-control-max-age"),
        NAME_BITS'("access-control-expose-headers"),
        NAME_BITS'("access-control-allow-credentials")
    };

    localparam logic [COUNT_W-1:0] NAME_LEN [NUM_NAMES] = '{
        6'd4,  6'd4,  6'd4,  6'd5,  6'd6,  6'd8,  6'd10, 6'd10,
        6'd12, 6'd13, 6'd13, 6'd13, 6'd13, 6'd14, 6'd16, 6'd17,
        6'd27, 6'd28, 6'd28, 6'd22, 6'd29, 6'd32
    };

    typedef struct packed {
        logic       take;
        logic [7:0] data;
        logic       last;
        logic       no_char;
    } step_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // byte at position pos of name idx, valid only when pos < length
    function automatic logic [7:0] name_byte(input int idx, input logic [COUNT_W-1:0] pos);
        logic [COUNT_W-1:0] off;
        off = NAME_LEN[idx] - pos - 6'd1;
        return NAME_STR[idx][{off[4:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

/* hdl/hrhc_match.sv */
// candidate mask and length counter with per-word match update
// depends on hrhc_pkg
`default_nettype none

module hrhc_match
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hrhc_pkg::step_t              step,
    output logic [hrhc_pkg::CODE_W-1:0]       code
);

    logic [hrhc_pkg::NUM_NAMES-1:0] alive_reg;
    logic [hrhc_pkg::NUM_NAMES-1:0] alive_next;
    logic [hrhc_pkg::COUNT_W-1:0]   count_reg;
    logic [hrhc_pkg::COUNT_W-1:0]   count_next;
    logic [hrhc_pkg::NUM_NAMES-1:0] hit;
    logic [hrhc_pkg::COUNT_W-1:0]   count_inc;
    logic [7:0]                     folded;

    always_comb
    begin
        folded = hrhc_pkg::fold_byte(step.data);
        for (int i = 0; i < hrhc_pkg::NUM_NAMES; i++)
        begin
            hit[i] = alive_reg[i] && (count_reg < hrhc_pkg::NAME_LEN[i])
                     && (hrhc_pkg::name_byte(i, count_reg) == folded);
        end
        count_inc = (count_reg == hrhc_pkg::COUNT_MAX) ? count_reg : count_reg + 6'd1;
        alive_next = step.no_char ? alive_reg : hit;
        count_next = step.no_char ? count_reg : count_inc;
    end

    // lowest index wins
    always_comb
    begin
        code = hrhc_pkg::CODE_UNKNOWN;
        for (int i = hrhc_pkg::NUM_NAMES - 1; i >= 0; i--)
        begin
            if (alive_next[i] && count_next == hrhc_pkg::NAME_LEN[i])
            begin
                code = hrhc_pkg::CODE_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= hrhc_pkg::ALL_ALIVE;
            count_reg <= '0;
        end
        else if (step.take)
        begin
            if (step.last)
            begin
                alive_reg <= hrhc_pkg::ALL_ALIVE;
                count_reg <= '0;
            end
            else
            begin
                alive_reg <= alive_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/http_response_header_classifier.sv */
// top level of the http response header name classifier
// depends on hrhc_pkg, hrhc_match and http_response_header_classifier_assert.svh
//
// input channel: char_valid / char_stall carry one word per name byte
// (name_char, is_last, no_char); no_char marks a word without a byte
// output channel: code_valid / code_stall carry header_code, one word per
// name, given for the word with is_last set (0 unknown or empty, 1..22)
// a word is taken when valid is high and stall is low at a rising edge
// an input word waits in the input register; its code is then written to the result register
// throughput: one input word per cycle while char_stall is low; the mask
// update sits between the input register and the result register
// a waiting result does not block words that give no result; the input
// stalls only when a last word meets a full, stalled result register
// reset (rst_n low, asynchronous) empties both registers, sets every
// candidate alive and clears the length counter
`default_nettype none

`include "http_response_header_classifier_assert.svh"

module http_response_header_classifier
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          char_valid,
    output logic                               char_stall,
    input  wire logic [7:0]                    name_char,
    input  wire logic                          is_last,
    input  wire logic                          no_char,
    output logic                               code_valid,
    input  wire logic                          code_stall,
    output logic [hrhc_pkg::CODE_W-1:0]        header_code
);

    logic                          stage_valid_reg;
    logic [7:0]                    stage_char_reg;
    logic                          stage_last_reg;
    logic                          stage_no_char_reg;
    logic                          code_valid_reg;
    logic [hrhc_pkg::CODE_W-1:0]   code_reg;
    logic                          advance;
    logic [hrhc_pkg::CODE_W-1:0]   match_code;
    hrhc_pkg::step_t               step;

    assign advance    = !stage_last_reg || !code_valid_reg || !code_stall;
    assign char_stall = stage_valid_reg && !advance;

    always_comb
    begin
        step.take    = stage_valid_reg && advance;
        step.data    = stage_char_reg;
        step.last    = stage_last_reg;
        step.no_char = stage_no_char_reg;
    end

    hrhc_match u_match
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .code  (match_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            stage_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            stage_char_reg    <= name_char;
            stage_last_reg    <= is_last;
            stage_no_char_reg <= no_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= 1'b0;
        end
        else if (step.take && stage_last_reg)
        begin
            code_valid_reg <= 1'b1;
        end
        else if (!code_stall)
        begin
            code_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.take && stage_last_reg)
        begin
            code_reg <= match_code;
        end
    end

    assign code_valid  = code_valid_reg;
    assign header_code = code_reg;

    `HRHC_ASSERT_NOW(a_code_range, code_valid, header_code <= hrhc_pkg::CODE_W'(hrhc_pkg::NUM_NAMES))
    `HRHC_ASSERT_NOW(a_stall_needs_last, char_stall, stage_valid_reg && stage_last_reg && code_valid_reg)
    `HRHC_ASSERT_NEXT(a_no_spurious_code, (!code_valid || !code_stall) && !(step.take && stage_last_reg), !code_valid)

endmodule

`default_nettype wire
